>>> rtl/point_pole_field_direction_top_defines.svh
// Assertion macros shared by the checker.
`ifndef POINT_POLE_FIELD_DIRECTION_TOP_DEFINES_SVH
`define POINT_POLE_FIELD_DIRECTION_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PPFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that expr holds in the cycle after cond.
`define PPFD_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/ppfd_pkg.sv
package ppfd_pkg;

    localparam int MAX_POLES_DEF  = 64;
    localparam int COORD_BITS_DEF = 10;

    // Datapath width of the shared root and divide units
    localparam int DATA_W = 64;

    // Field accumulator: 48 bits signed, 32 fraction bits
    localparam int ACC_W = 48;
    localparam int SUM_W = ACC_W + 2;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 50'sd140737488355327;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -50'sd140737488355327;

    localparam logic [DATA_W-1:0] ONE_Q12 = 64'd4096;
    localparam int ROOT_SHIFT = 24;
    localparam int SHIFT_A    = 36;
    localparam int SHIFT_B    = 20;
    localparam int SHIFT_C    = 12;
    localparam int UNIT_SHIFT = 14;

    // Normalization window for the larger magnitude: [2^29, 2^30)
    localparam int NORM_LO = 29;
    localparam int NORM_HI = 30;
    localparam int NORM_W  = NORM_HI;

    localparam int OUT_W = 16;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Division pass of one pole term
    localparam logic [1:0] STAGE_A = 2'd0;
    localparam logic [1:0] STAGE_B = 2'd1;
    localparam logic [1:0] STAGE_C = 2'd2;

    typedef struct packed {
        logic load;
        logic rotate;
    } cell_ctl_t;

endpackage

>>> rtl/ppfd_cell.sv
module ppfd_cell #(
    parameter int CW = ppfd_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  ppfd_pkg::cell_ctl_t ctl,
    input  logic [CW-1:0]       new_x,
    input  logic [CW-1:0]       new_y,
    input  logic                new_sign,
    input  logic [CW-1:0]       nb_x,
    input  logic [CW-1:0]       nb_y,
    input  logic                nb_sign,
    output logic [CW-1:0]       x,
    output logic [CW-1:0]       y,
    output logic                sign
);

    logic [CW-1:0] x_reg;
    logic [CW-1:0] y_reg;
    logic          sign_reg;

    // Load a new pole, or take the neighbor's pole while the row rotates
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg    <= new_x;
            y_reg    <= new_y;
            sign_reg <= new_sign;
        end
        else if (ctl.rotate)
        begin
            x_reg    <= nb_x;
            y_reg    <= nb_y;
            sign_reg <= nb_sign;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign sign = sign_reg;

endmodule

>>> rtl/ppfd_sqrt.sv
module ppfd_sqrt #(
    parameter int W = ppfd_pkg::DATA_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  logic [W-1:0]   val,
    output logic           done,
    output logic [W/2-1:0] root
);

    logic         run_reg;
    logic         done_reg;
    logic [W-1:0] v_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] bit_reg;
    logic [W-1:0] trial;
    logic         fits;
    logic         last;

    assign trial = r_reg + bit_reg;
    assign fits  = (v_reg >= trial);
    assign last  = (bit_reg == W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && last;
            if (go)
                run_reg <= 1'b1;
            else if (last)
                run_reg <= 1'b0;
        end
    end

    // One result bit per cycle, two radicand bits consumed
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            v_reg   <= val;
            r_reg   <= '0;
            bit_reg <= W'(1) << (W - 2);
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[W/2-1:0];

endmodule

>>> rtl/ppfd_div.sv
module ppfd_div #(
    parameter int W = ppfd_pkg::DATA_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == '0);
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    run_reg <= 1'b0;
            end
        end
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? diff[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/point_pole_field_direction_top.sv
// Point pole field direction. A transaction is taken when start is high and
// busy is low; each transaction gives exactly one result, shown for one cycle
// with done high, and the receiver cannot stall it. An add (op = 0) stores a
// pole if the table has room and reports add_accepted in the next cycle. A
// query (op = 1) walks the stored poles in order of arrival (per pole one
// square root of 32 steps and three 64-step serial divisions, x and y side by
// side), then the pole row turns back to its home position, then, if the
// summed field is not zero, normalization shifts plus one more root and one
// more 64-step division follow.
module point_pole_field_direction_top #(
    parameter int MAX_POLES  = ppfd_pkg::MAX_POLES_DEF,
    parameter int COORD_BITS = ppfd_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  op,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic                  positive_pole,
    output logic                  done,
    output logic signed [15:0]    dir_x,
    output logic signed [15:0]    dir_y,
    output logic                  field_nonzero,
    output logic                  add_accepted
);

    localparam int CW    = COORD_BITS;
    localparam int CNT_W = $clog2(MAX_POLES + 1);
    localparam int D2_W  = 2 * CW + 1;
    localparam int DW    = ppfd_pkg::DATA_W;
    localparam int AW    = ppfd_pkg::ACC_W;
    localparam int SW    = ppfd_pkg::SUM_W;
    localparam int NW    = ppfd_pkg::NORM_W;
    localparam int OW    = ppfd_pkg::OUT_W;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DIFF   = 12'b000000000010,
        S_MUL    = 12'b000000000100,
        S_ROOT   = 12'b000000001000,
        S_DIV    = 12'b000000010000,
        S_ACC    = 12'b000000100000,
        S_SPIN   = 12'b000001000000,
        S_NSTART = 12'b000010000000,
        S_NSHIFT = 12'b000100000000,
        S_NMUL   = 12'b001000000000,
        S_NROOT  = 12'b010000000000,
        S_NDIV   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_inc;
    logic [1:0]       stage_reg;
    logic             sqrt_go_reg;
    logic             div_go_reg;
    logic             done_reg;

    logic [CW-1:0]    qx_reg, qy_reg;
    logic [CW-1:0]    ax_reg, ay_reg;
    logic             negx_reg, negy_reg, psign_reg;
    logic [D2_W-1:0]  d2_reg;
    logic [DW-1:0]    d_reg;
    logic signed [AW-1:0] fx_reg, fy_reg;
    logic [AW-1:0]    ux_reg, uy_reg;
    logic [2*NW-1:0]  sqx_reg, sqy_reg;
    logic [DW/2-1:0]  len_reg;
    logic signed [OW-1:0] dir_x_reg, dir_y_reg;
    logic             nz_reg, acc_reg;

    // Pole row
    logic [CW-1:0]    cx [MAX_POLES];
    logic [CW-1:0]    cy [MAX_POLES];
    logic             cs [MAX_POLES];
    logic             add_wr;
    logic             rotate;

    logic                 take;
    logic                 has_room;
    logic signed [CW:0]   dx, dy;
    logic [2*CW-1:0]      sq_ax, sq_ay;

    logic             sqrt_done;
    logic [DW/2-1:0]  sqrt_root;
    logic [DW-1:0]    sqrt_in;
    logic             divx_done, divy_done;
    logic             div_done;
    logic [DW-1:0]    qx_div, qy_div;
    logic [DW-1:0]    divx_num, divy_num, div_den;

    logic signed [SW-1:0] tx, ty, sx, sy;
    logic signed [AW-1:0] fx_sat, fy_sat;
    logic [AW-1:0]        m;
    logic [OW-1:0]        magx, magy;

    assign take     = start && (state_reg == S_IDLE);
    assign has_room = (count_reg < CNT_W'(MAX_POLES));
    assign add_wr   = take && (op == ppfd_pkg::OP_ADD) && has_room;
    assign rotate   = state_reg inside {S_ACC, S_SPIN};
    assign idx_inc  = idx_reg + 1'b1;

    for (genvar i = 0; i < MAX_POLES; i++)
    begin : g_cell
        ppfd_pkg::cell_ctl_t ctl;
        assign ctl.load   = add_wr && (count_reg == CNT_W'(i));
        assign ctl.rotate = rotate;

        ppfd_cell #(.CW(CW)) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .new_x    (pos_x),
            .new_y    (pos_y),
            .new_sign (positive_pole),
            .nb_x     (cx[(i + 1) % MAX_POLES]),
            .nb_y     (cy[(i + 1) % MAX_POLES]),
            .nb_sign  (cs[(i + 1) % MAX_POLES]),
            .x        (cx[i]),
            .y        (cy[i]),
            .sign     (cs[i])
        );
    end

    // Difference to the pole at the head of the row
    assign dx = $signed({1'b0, qx_reg}) - $signed({1'b0, cx[0]});
    assign dy = $signed({1'b0, qy_reg}) - $signed({1'b0, cy[0]});
    assign sq_ax = ax_reg * ax_reg;
    assign sq_ay = ay_reg * ay_reg;

    // Shared root: pole distance, then the length of the summed field
    assign sqrt_in = (state_reg == S_NROOT)
                   ? DW'({1'b0, sqx_reg} + {1'b0, sqy_reg})
                   : (DW'(d2_reg) << ppfd_pkg::ROOT_SHIFT);

    ppfd_sqrt #(.W(DW)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (sqrt_go_reg),
        .val   (sqrt_in),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // Dividend per pass: |c| << 36, a << 20, b << 12; unit scaling at the end
    always_comb
    begin
        if (state_reg == S_NDIV)
        begin
            divx_num = DW'(ux_reg) << ppfd_pkg::UNIT_SHIFT;
            divy_num = DW'(uy_reg) << ppfd_pkg::UNIT_SHIFT;
            div_den  = DW'(len_reg);
        end
        else
        begin
            case (stage_reg)
                ppfd_pkg::STAGE_A:
                begin
                    divx_num = DW'(ax_reg) << ppfd_pkg::SHIFT_A;
                    divy_num = DW'(ay_reg) << ppfd_pkg::SHIFT_A;
                end
                ppfd_pkg::STAGE_B:
                begin
                    divx_num = qx_div << ppfd_pkg::SHIFT_B;
                    divy_num = qy_div << ppfd_pkg::SHIFT_B;
                end
                default:
                begin
                    divx_num = qx_div << ppfd_pkg::SHIFT_C;
                    divy_num = qy_div << ppfd_pkg::SHIFT_C;
                end
            endcase
            div_den = d_reg;
        end
    end

    ppfd_div #(.W(DW)) u_divx (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go_reg),
        .dividend (divx_num),
        .divisor  (div_den),
        .done     (divx_done),
        .quotient (qx_div)
    );

    ppfd_div #(.W(DW)) u_divy (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go_reg),
        .dividend (divy_num),
        .divisor  (div_den),
        .done     (divy_done),
        .quotient (qy_div)
    );

    // The y divider runs in lockstep with the x divider
    assign div_done = divx_done && divy_done;

    // Signed term, saturating accumulate
    assign tx = (negx_reg ^ ~psign_reg) ? -$signed({2'b00, qx_div[AW-1:0]})
                                         :  $signed({2'b00, qx_div[AW-1:0]});
    assign ty = (negy_reg ^ ~psign_reg) ? -$signed({2'b00, qy_div[AW-1:0]})
                                         :  $signed({2'b00, qy_div[AW-1:0]});
    assign sx = $signed({{2{fx_reg[AW-1]}}, fx_reg}) + tx;
    assign sy = $signed({{2{fy_reg[AW-1]}}, fy_reg}) + ty;

    always_comb
    begin
        if (sx > ppfd_pkg::SUM_MAX)
            fx_sat = AW'(ppfd_pkg::SUM_MAX);
        else if (sx < ppfd_pkg::SUM_MIN)
            fx_sat = AW'(ppfd_pkg::SUM_MIN);
        else
            fx_sat = sx[AW-1:0];
        if (sy > ppfd_pkg::SUM_MAX)
            fy_sat = AW'(ppfd_pkg::SUM_MAX);
        else if (sy < ppfd_pkg::SUM_MIN)
            fy_sat = AW'(ppfd_pkg::SUM_MIN);
        else
            fy_sat = sy[AW-1:0];
    end

    assign m    = (ux_reg > uy_reg) ? ux_reg : uy_reg;
    assign magx = qx_div[OW-1:0];
    assign magy = qy_div[OW-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (take && (op == ppfd_pkg::OP_QUERY))
                    state_next = (count_reg == '0) ? S_NSTART : S_DIFF;
            S_DIFF:
                state_next = S_MUL;
            S_MUL:
                state_next = S_ROOT;
            S_ROOT:
                if (sqrt_done)
                    state_next = S_DIV;
            S_DIV:
                if (div_done && (stage_reg == ppfd_pkg::STAGE_C))
                    state_next = S_ACC;
            S_ACC:
                if (idx_inc == count_reg)
                    state_next = (idx_inc == CNT_W'(MAX_POLES)) ? S_NSTART : S_SPIN;
                else
                    state_next = S_DIFF;
            S_SPIN:
                if (idx_inc == CNT_W'(MAX_POLES))
                    state_next = S_NSTART;
            S_NSTART:
                state_next = ((fx_reg == '0) && (fy_reg == '0)) ? S_IDLE : S_NSHIFT;
            S_NSHIFT:
                if ((m[AW-1:NW] == '0) && m[ppfd_pkg::NORM_LO])
                    state_next = S_NMUL;
            S_NMUL:
                state_next = S_NROOT;
            S_NROOT:
                if (sqrt_done)
                    state_next = S_NDIV;
            S_NDIV:
                if (div_done)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            stage_reg   <= ppfd_pkg::STAGE_A;
            sqrt_go_reg <= 1'b0;
            div_go_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sqrt_go_reg <= state_reg inside {S_MUL, S_NMUL};
            div_go_reg  <= 1'b0;
            done_reg    <= 1'b0;

            if (add_wr)
                count_reg <= count_reg + 1'b1;

            if (take)
                idx_reg <= '0;
            else if (rotate)
                idx_reg <= idx_inc;

            // Launch the division passes of one pole, then the final scaling
            if ((state_reg == S_ROOT) && sqrt_done)
            begin
                stage_reg  <= ppfd_pkg::STAGE_A;
                div_go_reg <= 1'b1;
            end
            else if ((state_reg == S_DIV) && div_done
                     && (stage_reg != ppfd_pkg::STAGE_C))
            begin
                stage_reg  <= stage_reg + 1'b1;
                div_go_reg <= 1'b1;
            end
            else if ((state_reg == S_NROOT) && sqrt_done)
            begin
                div_go_reg <= 1'b1;
            end

            if (take && (op == ppfd_pkg::OP_ADD))
                done_reg <= 1'b1;
            else if ((state_reg == S_NSTART) && (fx_reg == '0) && (fy_reg == '0))
                done_reg <= 1'b1;
            else if ((state_reg == S_NDIV) && div_done)
                done_reg <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
            fx_reg <= '0;
            fy_reg <= '0;
        end

        if (state_reg == S_DIFF)
        begin
            negx_reg  <= dx[CW];
            negy_reg  <= dy[CW];
            ax_reg    <= dx[CW] ? CW'(-dx) : CW'(dx);
            ay_reg    <= dy[CW] ? CW'(-dy) : CW'(dy);
            psign_reg <= cs[0];
        end

        if (state_reg == S_MUL)
            d2_reg <= D2_W'(sq_ax) + D2_W'(sq_ay);

        if ((state_reg == S_ROOT) && sqrt_done)
            d_reg <= DW'(sqrt_root) + ppfd_pkg::ONE_Q12;

        if (state_reg == S_ACC)
        begin
            fx_reg <= fx_sat;
            fy_reg <= fy_sat;
        end

        if (state_reg == S_NSTART)
        begin
            ux_reg <= fx_reg[AW-1] ? AW'(-fx_reg) : AW'(fx_reg);
            uy_reg <= fy_reg[AW-1] ? AW'(-fy_reg) : AW'(fy_reg);
        end
        else if (state_reg == S_NSHIFT)
        begin
            if (m[AW-1:NW] != '0)
            begin
                ux_reg <= ux_reg >> 1;
                uy_reg <= uy_reg >> 1;
            end
            else if (!m[ppfd_pkg::NORM_LO])
            begin
                ux_reg <= ux_reg << 1;
                uy_reg <= uy_reg << 1;
            end
        end

        if (state_reg == S_NMUL)
        begin
            sqx_reg <= ux_reg[NW-1:0] * ux_reg[NW-1:0];
            sqy_reg <= uy_reg[NW-1:0] * uy_reg[NW-1:0];
        end

        if ((state_reg == S_NROOT) && sqrt_done)
            len_reg <= sqrt_root;

        // Result registers
        if (take && (op == ppfd_pkg::OP_ADD))
        begin
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            nz_reg    <= 1'b0;
            acc_reg   <= has_room;
        end
        else if (state_reg == S_NSTART)
        begin
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            nz_reg    <= 1'b0;
            acc_reg   <= 1'b0;
        end
        else if ((state_reg == S_NDIV) && div_done)
        begin
            dir_x_reg <= fx_reg[AW-1] ? -$signed(magx) : $signed(magx);
            dir_y_reg <= fy_reg[AW-1] ? -$signed(magy) : $signed(magy);
            nz_reg    <= 1'b1;
            acc_reg   <= 1'b0;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign dir_x         = dir_x_reg;
    assign dir_y         = dir_y_reg;
    assign field_nonzero = nz_reg;
    assign add_accepted  = acc_reg;

endmodule

>>> rtl/ppfd_checker.sv
`include "point_pole_field_direction_top_defines.svh"

module ppfd_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  op,
    input logic                  done,
    input logic signed [15:0]    dir_x,
    input logic signed [15:0]    dir_y,
    input logic                  field_nonzero,
    input logic                  add_accepted
);

    // An add answers in the next cycle
    `PPFD_ASSERT_NEXT(a_add_answers, start && !busy && !op, done, "add gave no result")

    // A query holds the block busy
    `PPFD_ASSERT_NEXT(a_query_busy, start && !busy && op, busy && !done, "query not held")

    `PPFD_ASSERT(a_flags_apart, done |-> !(add_accepted && field_nonzero), "both flags set")

    `PPFD_ASSERT(a_zero_dir,
        (done && !field_nonzero) |-> (dir_x == 16'sd0 && dir_y == 16'sd0),
        "direction without field")

    `PPFD_ASSERT(a_unit_range,
        (done && field_nonzero) |-> (dir_x <= 16'sd16384 && dir_x >= -16'sd16384
            && dir_y <= 16'sd16384 && dir_y >= -16'sd16384),
        "direction out of range")

endmodule

bind point_pole_field_direction_top ppfd_checker u_ppfd_checker (.*);

>>> tb/tb_point_pole_field_direction_top.sv
`timescale 1ns / 100ps

module tb_point_pole_field_direction_top;

    localparam int POLES    = ppfd_pkg::MAX_POLES_DEF;
    localparam int CBITS    = ppfd_pkg::COORD_BITS_DEF;
    localparam logic [CBITS-1:0] CMAX = '1;
    // Even if every transaction were a worst-case query with a full table,
    // this limit would leave ample margin.
    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic               field_nonzero;
        logic               add_accepted;
    } field_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  op;
    logic [CBITS-1:0]      pos_x;
    logic [CBITS-1:0]      pos_y;
    logic                  positive_pole;
    logic                  done;
    logic signed [15:0]    dir_x;
    logic signed [15:0]    dir_y;
    logic                  field_nonzero;
    logic                  add_accepted;

    // Shadow copy of the pole table, updated as each add is accepted
    logic [CBITS-1:0]      shadow_x [POLES];
    logic [CBITS-1:0]      shadow_y [POLES];
    logic                  shadow_sign [POLES];
    int                    shadow_count;

    field_result_t         pending_results [$];
    int                    error_count;
    int                    cycle_count;

    point_pole_field_direction_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .positive_pole (positive_pole),
        .done          (done),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .field_nonzero (field_nonzero),
        .add_accepted  (add_accepted)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Bit-by-bit integer square root, floor of the true root
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned bitpos;
        r = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (v >= r + bitpos)
            begin
                v = v - (r + bitpos);
                r = (r >> 1) + bitpos;
            end
            else
                r = r >> 1;
            bitpos = bitpos >> 2;
        end
        return r;
    endfunction

    // |c| / dist^3 in Q.32 through three truncating divisions by D
    function automatic longint unsigned inv_cube_term(input longint unsigned c,
                                                      input longint unsigned d);
        longint unsigned a;
        longint unsigned b;
        a = (c << ppfd_pkg::SHIFT_A) / d;
        b = (a << ppfd_pkg::SHIFT_B) / d;
        return (b << ppfd_pkg::SHIFT_C) / d;
    endfunction

    function automatic longint clamp_sum(input longint acc, input longint t);
        longint s;
        longint lim;
        lim = (longint'(1) << 47) - 1;
        s = acc + t;
        if (s > lim)
            s = lim;
        if (s < -lim)
            s = -lim;
        return s;
    endfunction

    // Direction of the summed field at (qx, qy) over the shadow table
    function automatic field_result_t field_at_point(input logic [CBITS-1:0] qx,
                                                     input logic [CBITS-1:0] qy);
        field_result_t   res;
        longint          fx;
        longint          fy;
        longint          ddx;
        longint          ddy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned dist_q12;
        longint          tx;
        longint          ty;
        longint unsigned ux;
        longint unsigned uy;
        longint unsigned m;
        longint unsigned len;
        longint          rx;
        longint          ry;
        res = '0;
        fx = 0;
        fy = 0;
        for (int i = 0; i < shadow_count; i++)
        begin
            ddx = longint'(qx) - longint'(shadow_x[i]);
            ddy = longint'(qy) - longint'(shadow_y[i]);
            ax = (ddx < 0) ? -ddx : ddx;
            ay = (ddy < 0) ? -ddy : ddy;
            dist_q12 = int_sqrt((ax * ax + ay * ay) << ppfd_pkg::ROOT_SHIFT)
                     + ppfd_pkg::ONE_Q12;
            tx = inv_cube_term(ax, dist_q12);
            ty = inv_cube_term(ay, dist_q12);
            if (ddx < 0)
                tx = -tx;
            if (ddy < 0)
                ty = -ty;
            if (!shadow_sign[i])
            begin
                tx = -tx;
                ty = -ty;
            end
            fx = clamp_sum(fx, tx);
            fy = clamp_sum(fy, ty);
        end
        if (fx != 0 || fy != 0)
        begin
            ux = (fx < 0) ? -fx : fx;
            uy = (fy < 0) ? -fy : fy;
            m = (ux > uy) ? ux : uy;
            while (m >= (64'd1 << ppfd_pkg::NORM_HI))
            begin
                m = m >> 1;
                ux = ux >> 1;
                uy = uy >> 1;
            end
            while (m < (64'd1 << ppfd_pkg::NORM_LO))
            begin
                m = m << 1;
                ux = ux << 1;
                uy = uy << 1;
            end
            len = int_sqrt(ux * ux + uy * uy);
            rx = (ux << ppfd_pkg::UNIT_SHIFT) / len;
            ry = (uy << ppfd_pkg::UNIT_SHIFT) / len;
            if (fx < 0)
                rx = -rx;
            if (fy < 0)
                ry = -ry;
            res.dir_x = rx[15:0];
            res.dir_y = ry[15:0];
            res.field_nonzero = 1'b1;
        end
        return res;
    endfunction

    // Random idle length: mostly short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 120);
    endfunction

    // Drive one transaction and record what it should return.
    task automatic send_item(input logic item_op, input logic [CBITS-1:0] x,
                             input logic [CBITS-1:0] y, input logic sign);
        int            gap;
        field_result_t exp_res;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        op            <= item_op;
        pos_x         <= x;
        pos_y         <= y;
        positive_pole <= sign;
        // Hold start until the block takes the transaction
        do
            @(posedge clk);
        while (busy);
        exp_res = '0;
        if (item_op == ppfd_pkg::OP_ADD)
        begin
            if (shadow_count < POLES)
            begin
                shadow_x[shadow_count]    = x;
                shadow_y[shadow_count]    = y;
                shadow_sign[shadow_count] = sign;
                shadow_count++;
                exp_res.add_accepted = 1'b1;
            end
        end
        else
            exp_res = field_at_point(x, y);
        pending_results.insert(pending_results.size(), exp_res);
    endtask

    task automatic release_start();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Pause the sender until every outstanding result has come back.
    task automatic wait_all_results();
        release_start();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_item(ppfd_pkg::OP_QUERY, '0, '0, 1'b1);
        send_item(ppfd_pkg::OP_QUERY, CMAX, CMAX, 1'b0);
    endtask

    task automatic test_directed_extremes();
        send_item(ppfd_pkg::OP_ADD, '0, '0, 1'b1);
        send_item(ppfd_pkg::OP_QUERY, '0, '0, 1'b0);      // pole under the query point
        send_item(ppfd_pkg::OP_QUERY, CMAX, CMAX, 1'b1);
        send_item(ppfd_pkg::OP_QUERY, 10'd1, 10'd0, 1'b0);
        send_item(ppfd_pkg::OP_ADD, CMAX, CMAX, 1'b0);
        send_item(ppfd_pkg::OP_QUERY, CMAX, '0, 1'b1);
        send_item(ppfd_pkg::OP_QUERY, '0, CMAX, 1'b0);
        send_item(ppfd_pkg::OP_ADD, 10'd512, 10'd512, 1'b1);
        send_item(ppfd_pkg::OP_ADD, 10'd512, 10'd512, 1'b0);  // cancels the previous one
        send_item(ppfd_pkg::OP_QUERY, 10'd300, 10'd700, 1'b1);
        send_item(ppfd_pkg::OP_QUERY, 10'd512, 10'd513, 1'b0);
        wait_all_results();
    endtask

    task automatic test_random_mix(input int n_items);
        logic [CBITS-1:0] x;
        logic [CBITS-1:0] y;
        int               idx;
        for (int k = 0; k < n_items; k++)
        begin
            x = CBITS'($urandom_range(0, CMAX));
            y = CBITS'($urandom_range(0, CMAX));
            if ($urandom_range(0, 99) < 45)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    x = ($urandom_range(0, 1) != 0) ? CMAX : '0;
                    y = ($urandom_range(0, 1) != 0) ? CMAX : '0;
                end
                send_item(ppfd_pkg::OP_ADD, x, y, 1'($urandom_range(0, 1)));
            end
            else
            begin
                // Probe near a stored pole now and then for steep fields
                if (shadow_count > 0 && $urandom_range(0, 2) == 0)
                begin
                    idx = $urandom_range(0, shadow_count - 1);
                    x = shadow_x[idx] + CBITS'($urandom_range(0, 4)) - CBITS'(2);
                    y = shadow_y[idx] + CBITS'($urandom_range(0, 4)) - CBITS'(2);
                end
                send_item(ppfd_pkg::OP_QUERY, x, y, 1'($urandom_range(0, 1)));
            end
            if (k == n_items / 2)
                wait_all_results();
        end
        wait_all_results();
    endtask

    task automatic test_table_full();
        while (shadow_count < POLES)
            send_item(ppfd_pkg::OP_ADD, CBITS'($urandom_range(0, CMAX)),
                      CBITS'($urandom_range(0, CMAX)), 1'($urandom_range(0, 1)));
        // Further adds must be refused and leave the table alone
        send_item(ppfd_pkg::OP_ADD, CMAX, '0, 1'b1);
        send_item(ppfd_pkg::OP_ADD, '0, CMAX, 1'b0);
        send_item(ppfd_pkg::OP_QUERY, CBITS'($urandom_range(0, CMAX)),
                  CBITS'($urandom_range(0, CMAX)), 1'b0);
        send_item(ppfd_pkg::OP_ADD, 10'd5, 10'd5, 1'b1);
        send_item(ppfd_pkg::OP_QUERY, shadow_x[0], shadow_y[0], 1'b1);
        wait_all_results();
    endtask

    // Compare every result against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        field_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no outstanding transaction");
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (dir_x !== exp_res.dir_x)
                begin
                    $error("dir_x expected %0d actual %0d", exp_res.dir_x, dir_x);
                    error_count++;
                end
                if (dir_y !== exp_res.dir_y)
                begin
                    $error("dir_y expected %0d actual %0d", exp_res.dir_y, dir_y);
                    error_count++;
                end
                if (field_nonzero !== exp_res.field_nonzero)
                begin
                    $error("field_nonzero expected %0d actual %0d",
                           exp_res.field_nonzero, field_nonzero);
                    error_count++;
                end
                if (add_accepted !== exp_res.add_accepted)
                begin
                    $error("add_accepted expected %0d actual %0d",
                           exp_res.add_accepted, add_accepted);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        error_count   = 0;
        cycle_count   = 0;
        shadow_count  = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        op            = ppfd_pkg::OP_ADD;
        pos_x         = '0;
        pos_y         = '0;
        positive_pole = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_directed_extremes();
        test_random_mix(110);
        test_table_full();

        // Drain: everything has arrived, let the block run on idle before the check
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
